// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the NAL splitter RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, held off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property that must not hold on any rising edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

// ===== rtl/anbs_pkg.sv =====
// ---------------------------------------------------------------------------
// anbs_pkg
// Types and constants shared by the Annex B NAL splitter modules.
// ---------------------------------------------------------------------------
package anbs_pkg;

	// Field widths of the result
	localparam int NAL_LEN_W   = 24;
	localparam int KIND_W      = 5;
	localparam int SC_LEN_W    = 3;
	localparam int NAL_IDX_W   = 4;
	localparam int TS_W        = 33;
	localparam int TS_INC_W    = 17;

	// Byte codes and NAL types
	localparam logic [7:0]        BYTE_ZERO     = 8'h00;
	localparam logic [7:0]        BYTE_ONE      = 8'h01;
	localparam logic [KIND_W-1:0] KIND_NON_IDR  = 5'd1;
	localparam logic [KIND_W-1:0] KIND_IDR      = 5'd5;
	localparam logic [KIND_W-1:0] KIND_NONE     = 5'd0;

	// Start code lengths
	localparam logic [SC_LEN_W-1:0] SC_LEN3 = 3'd3;
	localparam logic [SC_LEN_W-1:0] SC_LEN4 = 3'd4;

	// Zero-run tracker saturates at three
	localparam logic [1:0] ZRUN_TWO = 2'd2;
	localparam logic [1:0] ZRUN_MAX = 2'd3;

	// Timestamp increment after reset (one frame at 25 fps in 90 kHz ticks)
	localparam logic [TS_INC_W-1:0] TS_INC_RESET = 17'd3600;

	// Decoupling queue between scanner and frame tracker
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = 3;

	// Closed unit as seen by the scanner
	typedef struct packed {
		logic [NAL_LEN_W-1:0] len;
		logic                 clamped;
		logic [KIND_W-1:0]    kind;
		logic [SC_LEN_W-1:0]  sc_len;
		logic                 force_end;
	} unit_rec_t;

	// Full result record
	typedef struct packed {
		logic [TS_W-1:0]      timestamp;
		logic                 is_idr;
		logic                 has_pic;
		logic [NAL_IDX_W-1:0] index;
		logic [SC_LEN_W-1:0]  sc_len;
		logic [KIND_W-1:0]    kind;
		logic                 saturated;
		logic [NAL_LEN_W-1:0] len;
	} result_t;

endpackage

// ===== rtl/anbs_front.sv =====
// ---------------------------------------------------------------------------
// anbs_front
// Start-code scanner: tracks zero runs, counts unit bytes and reports
// every closed unit as a record for the frame tracker.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module anbs_front #(
	parameter int LENGTH_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            byte_in,
	input  logic                  eos,
	output logic                  push,
	output anbs_pkg::unit_rec_t   rec
);

	localparam int LW = (LENGTH_BITS > anbs_pkg::NAL_LEN_W) ? LENGTH_BITS : anbs_pkg::NAL_LEN_W;
	localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

	logic [1:0]                      zrun_q;
	logic                            inside_q;
	logic                            hdr_pend_q;
	logic [LENGTH_BITS-1:0]          count_q;
	logic                            clamped_q;
	logic [anbs_pkg::KIND_W-1:0]     kind_q;
	logic [anbs_pkg::SC_LEN_W-1:0]   sc_len_q;

	logic                            start;
	logic [anbs_pkg::SC_LEN_W-1:0]   code_len;
	logic [LENGTH_BITS-1:0]          count_inc;
	logic                            clamped_inc;
	logic [anbs_pkg::KIND_W-1:0]     kind_upd;
	logic [LENGTH_BITS-1:0]          len_raw;
	logic [LW-1:0]                   len_ext;
	logic [1:0]                      zrun_next;

	// Start code detection
	assign start    = (byte_in == anbs_pkg::BYTE_ONE) && (zrun_q >= anbs_pkg::ZRUN_TWO);
	assign code_len = (zrun_q == anbs_pkg::ZRUN_MAX) ? anbs_pkg::SC_LEN4 : anbs_pkg::SC_LEN3;

	// Byte count, clamp and header capture for an ordinary byte
	always_comb begin
		count_inc   = count_q;
		clamped_inc = clamped_q;
		kind_upd    = kind_q;
		if (inside_q) begin
			if (count_q == COUNT_MAX) begin
				clamped_inc = 1'b1;
			end else begin
				count_inc = count_q + LENGTH_BITS'(1);
			end
			if (hdr_pend_q) begin
				kind_upd = byte_in[anbs_pkg::KIND_W-1:0];
			end
		end
		if (byte_in == anbs_pkg::BYTE_ZERO) begin
			zrun_next = (zrun_q == anbs_pkg::ZRUN_MAX) ? anbs_pkg::ZRUN_MAX : zrun_q + 2'd1;
		end else begin
			zrun_next = 2'd0;
		end
	end

	// Closed unit record: a new start code closes the open unit, a start code
	// on the final byte with no unit open reports that empty unit, else the
	// end of the stream closes the open unit with this byte included
	always_comb begin
		rec.sc_len = sc_len_q;
		if (start && inside_q) begin
			len_raw       = count_q - LENGTH_BITS'(code_len - anbs_pkg::SC_LEN_W'(1));
			rec.clamped   = clamped_q;
			rec.kind      = kind_q;
		end else if (start) begin
			len_raw       = LENGTH_BITS'(code_len);
			rec.clamped   = 1'b0;
			rec.kind      = anbs_pkg::KIND_NONE;
			rec.sc_len    = code_len;
		end else begin
			len_raw       = count_inc;
			rec.clamped   = clamped_inc;
			rec.kind      = kind_upd;
		end
		if (rec.clamped) begin
			len_raw = COUNT_MAX;
		end
		len_ext       = LW'(len_raw);
		rec.len       = len_ext[anbs_pkg::NAL_LEN_W-1:0];
		rec.force_end = eos;
	end

	assign push = accept && (inside_q ? (start || eos) : (start && eos));

	// Scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zrun_q     <= 2'd0;
			inside_q   <= 1'b0;
			hdr_pend_q <= 1'b0;
			count_q    <= '0;
			clamped_q  <= 1'b0;
			kind_q     <= anbs_pkg::KIND_NONE;
			sc_len_q   <= '0;
		end else if (accept) begin
			if (eos) begin
				zrun_q     <= 2'd0;
				inside_q   <= 1'b0;
				hdr_pend_q <= 1'b0;
				count_q    <= '0;
				clamped_q  <= 1'b0;
				kind_q     <= anbs_pkg::KIND_NONE;
				sc_len_q   <= '0;
			end else if (start) begin
				zrun_q     <= 2'd0;
				inside_q   <= 1'b1;
				hdr_pend_q <= 1'b1;
				count_q    <= LENGTH_BITS'(code_len);
				clamped_q  <= 1'b0;
				kind_q     <= anbs_pkg::KIND_NONE;
				sc_len_q   <= code_len;
			end else begin
				zrun_q     <= zrun_next;
				count_q    <= count_inc;
				clamped_q  <= clamped_inc;
				kind_q     <= kind_upd;
				if (inside_q) begin
					hdr_pend_q <= 1'b0;
				end
			end
		end
	end

	// A reported unit always carries a real start code length
	`ASSERT_CLK(a_front_sc_len, clk, arst_n,
		push |-> (rec.sc_len == anbs_pkg::SC_LEN3 || rec.sc_len == anbs_pkg::SC_LEN4),
		"closed unit without a valid start code length")
	// An open unit is never shorter than its own start code
	`ASSERT_CLK(a_front_count, clk, arst_n,
		inside_q |-> (count_q >= LENGTH_BITS'(sc_len_q)),
		"unit byte count below its start code length")

endmodule

// ===== rtl/anbs_queue.sv =====
// ---------------------------------------------------------------------------
// anbs_queue
// Small FIFO of closed-unit records between scanner and frame tracker.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module anbs_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  anbs_pkg::unit_rec_t  wdata,
	input  logic                 pop,
	output anbs_pkg::unit_rec_t  rdata,
	output logic                 full,
	output logic                 empty
);

	anbs_pkg::unit_rec_t                mem_q [anbs_pkg::Q_DEPTH];
	logic [anbs_pkg::Q_PTR_W-1:0]       wr_ptr_q;
	logic [anbs_pkg::Q_PTR_W-1:0]       rd_ptr_q;
	logic [anbs_pkg::Q_CNT_W-1:0]       cnt_q;

	assign full  = (cnt_q == anbs_pkg::Q_CNT_W'(anbs_pkg::Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + anbs_pkg::Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + anbs_pkg::Q_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + anbs_pkg::Q_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - anbs_pkg::Q_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`ASSERT_NEVER(a_queue_overflow, clk, arst_n, push && full, "push into full queue")
	`ASSERT_NEVER(a_queue_underflow, clk, arst_n, pop && empty, "pop from empty queue")
	`ASSERT_CLK(a_queue_level, clk, arst_n,
		(cnt_q <= anbs_pkg::Q_CNT_W'(anbs_pkg::Q_DEPTH)) &&
		((cnt_q == '0 || cnt_q == anbs_pkg::Q_CNT_W'(anbs_pkg::Q_DEPTH)) ==
		(wr_ptr_q == rd_ptr_q)),
		"queue level disagrees with pointers")

endmodule

// ===== rtl/anbs_back.sv =====
// ---------------------------------------------------------------------------
// anbs_back
// Frame tracker: numbers units within the frame, decides frame ends,
// runs the frame timestamp and holds the result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module anbs_back #(
	parameter int MAX_NALS_PER_FRAME = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [anbs_pkg::TS_INC_W-1:0]        cfg_inc,
	input  logic                                 q_empty,
	input  anbs_pkg::unit_rec_t                  q_rec,
	output logic                                 q_pop,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output anbs_pkg::result_t                    res,
	output logic                                 res_last
);

	localparam int IDX_W = (MAX_NALS_PER_FRAME > 1) ? $clog2(MAX_NALS_PER_FRAME) : 1;
	localparam int IW    = (IDX_W > anbs_pkg::NAL_IDX_W) ? IDX_W : anbs_pkg::NAL_IDX_W;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_NALS_PER_FRAME - 1);

	logic [anbs_pkg::TS_INC_W-1:0] ts_inc_q;
	logic [IDX_W-1:0]              idx_q;
	logic [anbs_pkg::TS_W-1:0]     ts_q;
	logic                          valid_q;
	anbs_pkg::result_t             res_q;
	logic                          last_q;

	logic                          pic;
	logic                          fend;
	logic [IW-1:0]                 idx_ext;
	anbs_pkg::result_t             res_next;

	// Take a record whenever the result register is free or being drained
	assign q_pop = !q_empty && (!valid_q || res_ready);

	// Frame decision for the record at the queue head
	always_comb begin
		pic      = (q_rec.kind == anbs_pkg::KIND_NON_IDR) || (q_rec.kind == anbs_pkg::KIND_IDR);
		fend     = pic || q_rec.force_end || (idx_q == IDX_LAST);
		idx_ext  = IW'(idx_q);
		res_next.len       = q_rec.len;
		res_next.saturated = q_rec.clamped;
		res_next.kind      = q_rec.kind;
		res_next.sc_len    = q_rec.sc_len;
		res_next.index     = idx_ext[anbs_pkg::NAL_IDX_W-1:0];
		res_next.has_pic   = fend && pic;
		res_next.is_idr    = fend && (q_rec.kind == anbs_pkg::KIND_IDR);
		res_next.timestamp = ts_q;
	end

	// Frame counter, timestamp and increment register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_inc_q <= anbs_pkg::TS_INC_RESET;
			idx_q    <= '0;
			ts_q     <= '0;
			valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				ts_inc_q <= cfg_inc;
			end
			if (q_pop) begin
				valid_q <= 1'b1;
				if (fend) begin
					idx_q <= '0;
					ts_q  <= ts_q + anbs_pkg::TS_W'(ts_inc_q);
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end else if (res_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q  <= res_next;
			last_q <= fend;
		end
	end

	// frame_end is carried separately as the last-of-frame mark
	assign res_valid = valid_q;
	assign res       = res_q;
	assign res_last  = last_q;

	`ASSERT_CLK(a_back_idr_pic, clk, arst_n, (valid_q && res_q.is_idr) |-> res_q.has_pic,
		"IDR frame flag without picture flag")
	`ASSERT_CLK(a_back_hold, clk, arst_n, (valid_q && !res_ready) |=> (valid_q && $stable(res_q)),
		"result register changed while stalled")

endmodule

// ===== rtl/annexb_nal_splitter_core.sv =====
// ---------------------------------------------------------------------------
// annexb_nal_splitter_core
// H.264 Annex B start-code NAL unit splitter, one stream byte per cycle while the unit queue has room.
// ---------------------------------------------------------------------------
// The block takes one Annex B byte per cycle (tlast marks the last byte of the
// stream) and returns one request per NAL unit once the next start code or the
// end of the stream closes it: length with start code, type, start code
// length, position in the frame, frame flags and the frame's 33-bit timestamp.
// Bytes before the first start code are dropped. A byte is taken every cycle
// as long as the four-entry unit queue has room; the record of a closed unit
// passes through the unit queue and then the output register, which drains
// one request per cycle while m_axis_tready stays high. tlast on the output
// side marks the unit that closes a frame. The timestamp increment is written
// through the cfg channel, which is always ready, and must only be changed
// while the block is idle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module annexb_nal_splitter_core #(
	parameter int MAX_NALS_PER_FRAME = 16,
	parameter int LENGTH_BITS        = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: timestamp increment
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [16:0] cfg_data,
	// Byte stream in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
	input  logic        s_axis_tlast,   // end_of_stream
	// Unit reports out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // [23:0] nal_length, [24] length_saturated,
	                                    // [29:25] nal_kind, [32:30] start_code_length,
	                                    // [36:33] nal_index, [37] frame_has_picture,
	                                    // [38] is_idr_frame, [71:39] frame_timestamp
	output logic        m_axis_tlast    // frame_end
);

	logic                 accept;
	logic                 push;
	logic                 pop;
	logic                 q_full;
	logic                 q_empty;
	anbs_pkg::unit_rec_t  wrec;
	anbs_pkg::unit_rec_t  rrec;
	anbs_pkg::result_t    res;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Scanner
	anbs_front #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.byte_in (s_axis_tdata),
		.eos     (s_axis_tlast),
		.push    (push),
		.rec     (wrec)
	);

	// Decoupling queue
	anbs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wrec),
		.pop    (pop),
		.rdata  (rrec),
		.full   (q_full),
		.empty  (q_empty)
	);

	// Frame tracker and result register; frame end travels beside the payload
	anbs_back #(
		.MAX_NALS_PER_FRAME (MAX_NALS_PER_FRAME)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_inc   (cfg_data),
		.q_empty   (q_empty),
		.q_rec     (rrec),
		.q_pop     (pop),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res),
		.res_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {res.timestamp, res.is_idr, res.has_pic, res.index,
	                       res.sc_len, res.kind, res.saturated, res.len};

	`ASSERT_CLK(a_top_pic_last, clk, arst_n,
		(m_axis_tvalid && res.has_pic) |-> m_axis_tlast,
		"picture flag on a unit that does not close its frame")

endmodule

// ===== dv/annexb_nal_splitter_core_tb.sv =====
// ---------------------------------------------------------------------------
// annexb_nal_splitter_core_tb
// Self-checking bench for the Annex B NAL splitter: a bursty byte driver,
// a stalling report monitor and a byte-level model of the unit tracker.
// ---------------------------------------------------------------------------
// Every accepted stream byte is fed through a local model of the start-code
// scanner and frame tracker; each unit report it predicts is queued and
// compared field by field with the next report taken from the block. The
// stream runs through several timestamp increments, a directed opening and
// random streams of well-formed units mixed with noise and broken sequences.
// ---------------------------------------------------------------------------
module annexb_nal_splitter_core_tb;
	import anbs_pkg::*;

	// Length counter narrower than the 24-bit result field
	localparam int LEN_BITS       = 16;
	localparam int NALS_PER_FRAME = 16;
	localparam logic [31:0] COUNT_CEIL = 32'((64'd1 << LEN_BITS) - 1);
	localparam int QUIET_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 1000000;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} stream_byte_t;

	typedef struct packed {
		logic [NAL_LEN_W-1:0] len;
		logic                 saturated;
		logic [KIND_W-1:0]    kind;
		logic [SC_LEN_W-1:0]  sc_len;
		logic [NAL_IDX_W-1:0] index;
		logic                 frame_end;
		logic                 has_pic;
		logic                 is_idr;
		logic [TS_W-1:0]      timestamp;
	} nal_report_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [16:0] cfg_data      = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;   // [7:0] byte_value
	logic        s_axis_tlast  = 1'b0; // end_of_stream
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;         // [23:0] nal_length, [24] length_saturated,
	                                   // [29:25] nal_kind, [32:30] start_code_length,
	                                   // [36:33] nal_index, [37] frame_has_picture,
	                                   // [38] is_idr_frame, [71:39] frame_timestamp
	logic        m_axis_tlast;         // frame_end

	// Stimulus and scoreboard
	stream_byte_t pending_bytes[$];
	nal_report_t  expected_reports[$];
	int           bytes_pushed   = 0;
	int           bytes_taken    = 0;
	int           mismatch_count = 0;
	int           report_seq     = 0;
	int           cycle_count    = 0;
	int           gap_max        = 0;
	logic [15:0]  ready_pattern  = 16'hFFFF;

	// Model state of the scanner and frame tracker
	logic [1:0]          zrun        = '0;
	bit                  in_unit     = 0;
	bit                  hdr_wait    = 0;
	logic [31:0]         unit_count  = '0;
	bit                  clamped     = 0;
	logic [KIND_W-1:0]   unit_kind   = KIND_NONE;
	logic [SC_LEN_W-1:0] unit_sc     = '0;
	int unsigned         frame_pos   = 0;
	logic [TS_W-1:0]     frame_ts    = '0;
	logic [TS_INC_W-1:0] ts_step     = TS_INC_RESET;

	annexb_nal_splitter_core #(
		.MAX_NALS_PER_FRAME(NALS_PER_FRAME),
		.LENGTH_BITS(LEN_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic log_mismatch(input string msg);
		mismatch_count++;
		$display("ERROR: %s", msg);
	endtask

	// Close the open unit and queue its report; steps the frame on its end
	task automatic close_nal_unit(input logic [31:0] len, input bit force_end);
		nal_report_t r;
		bit pic;
		bit fend;
		pic  = (unit_kind == KIND_NON_IDR) || (unit_kind == KIND_IDR);
		fend = pic || force_end || (frame_pos + 1 >= NALS_PER_FRAME);
		if (clamped)
			len = COUNT_CEIL;
		r.len       = len[NAL_LEN_W-1:0];
		r.saturated = clamped;
		r.kind      = unit_kind;
		r.sc_len    = unit_sc;
		r.index     = frame_pos[NAL_IDX_W-1:0];
		r.frame_end = fend;
		r.has_pic   = fend && pic;
		r.is_idr    = fend && (unit_kind == KIND_IDR);
		r.timestamp = frame_ts;
		expected_reports.push_back(r);
		if (fend) begin
			frame_pos = 0;
			frame_ts  = frame_ts + {{(TS_W-TS_INC_W){1'b0}}, ts_step};
		end else begin
			frame_pos++;
		end
	endtask

	// One stream byte through the start-code scanner
	task automatic track_stream_byte(input logic [7:0] b, input bit eos);
		bit closed;
		logic [SC_LEN_W-1:0] code_len;
		closed = 0;
		if (b == BYTE_ONE && zrun >= ZRUN_TWO) begin
			code_len = (zrun == ZRUN_MAX) ? SC_LEN4 : SC_LEN3;
			// zeros of the new code were counted into the old unit
			if (in_unit) begin
				close_nal_unit(unit_count - {29'd0, code_len} + 32'd1, eos);
				closed = 1;
			end
			in_unit    = 1;
			hdr_wait   = 1;
			unit_count = {29'd0, code_len};
			clamped    = 0;
			unit_kind  = KIND_NONE;
			unit_sc    = code_len;
			zrun       = '0;
		end else begin
			if (in_unit) begin
				if (unit_count >= COUNT_CEIL)
					clamped = 1;
				else
					unit_count++;
				if (hdr_wait) begin
					unit_kind = b[KIND_W-1:0];
					hdr_wait  = 0;
				end
			end
			if (b == BYTE_ZERO)
				zrun = (zrun == ZRUN_MAX) ? ZRUN_MAX : zrun + 2'd1;
			else
				zrun = '0;
		end
		// end of stream: close what is open, clear the scanner
		if (eos) begin
			if (!closed && in_unit)
				close_nal_unit(unit_count, 1);
			zrun       = '0;
			in_unit    = 0;
			hdr_wait   = 0;
			unit_count = '0;
			clamped    = 0;
			unit_kind  = KIND_NONE;
			unit_sc    = '0;
			frame_pos  = 0;
		end
	endtask

	// Byte driver: bursts of random length, random gaps between them
	always @(posedge clk or negedge arst_n) begin : byte_driver
		stream_byte_t head_byte;
		int burst_left;
		int gap_left;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tlast  <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				track_stream_byte(s_axis_tdata, s_axis_tlast);
				bytes_taken++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left != 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_bytes.size() == 0) begin
					s_axis_tvalid <= 1'b0;
				end else begin
					head_byte = pending_bytes.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= head_byte.data;
					s_axis_tlast  <= head_byte.last;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 32);
						if (gap_max == 0 || $urandom_range(0, 2) == 0)
							gap_left = 0;
						else
							gap_left = $urandom_range(1, gap_max);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// Report monitor: stalls on a rotating pattern, checks every request
	always @(posedge clk or negedge arst_n) begin : report_monitor
		result_t     got;
		nal_report_t want;
		string       diffs;
		logic [3:0]  stall_pos;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_pos = '0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				report_seq++;
				got = result_t'(m_axis_tdata);
				if (expected_reports.size() == 0) begin
					log_mismatch($sformatf("unit report %0d arrived with none expected",
						report_seq));
				end else begin
					want  = expected_reports.pop_front();
					diffs = "";
					if (got.len !== want.len)
						diffs = {diffs, $sformatf(" nal_length %0d/%0d", got.len, want.len)};
					if (got.saturated !== want.saturated)
						diffs = {diffs, $sformatf(" length_saturated %0b/%0b",
							got.saturated, want.saturated)};
					if (got.kind !== want.kind)
						diffs = {diffs, $sformatf(" nal_kind %0d/%0d", got.kind, want.kind)};
					if (got.sc_len !== want.sc_len)
						diffs = {diffs, $sformatf(" start_code_length %0d/%0d",
							got.sc_len, want.sc_len)};
					if (got.index !== want.index)
						diffs = {diffs, $sformatf(" nal_index %0d/%0d", got.index, want.index)};
					if (m_axis_tlast !== want.frame_end)
						diffs = {diffs, $sformatf(" frame_end %0b/%0b",
							m_axis_tlast, want.frame_end)};
					if (got.has_pic !== want.has_pic)
						diffs = {diffs, $sformatf(" frame_has_picture %0b/%0b",
							got.has_pic, want.has_pic)};
					if (got.is_idr !== want.is_idr)
						diffs = {diffs, $sformatf(" is_idr_frame %0b/%0b",
							got.is_idr, want.is_idr)};
					if (got.timestamp !== want.timestamp)
						diffs = {diffs, $sformatf(" frame_timestamp %0d/%0d",
							got.timestamp, want.timestamp)};
					if (diffs != "")
						log_mismatch($sformatf("unit report %0d (got/exp):%s",
							report_seq, diffs));
				end
			end
			m_axis_tready <= ready_pattern[stall_pos];
			stall_pos = stall_pos + 4'd1;
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("annexb_nal_splitter_core: mismatch");
			$finish;
		end
	end

	task automatic add_byte(input logic [7:0] b, input bit last);
		stream_byte_t item;
		item.data = b;
		item.last = last;
		pending_bytes.push_back(item);
		bytes_pushed++;
	endtask

	// n bytes from a literal, first byte in the top bits
	task automatic add_hex(input logic [127:0] bytes, input int n, input bit eos);
		for (int i = n - 1; i >= 0; i--)
			add_byte(bytes[8*i +: 8], eos && (i == 0));
	endtask

	function automatic logic [7:0] payload_byte();
		if ($urandom_range(0, 4) == 0)
			return BYTE_ZERO;
		return 8'($urandom_range(1, 255));
	endfunction

	task automatic add_start_code(input bit four, input bit eos);
		if (four)
			add_byte(BYTE_ZERO, 0);
		add_byte(BYTE_ZERO, 0);
		add_byte(BYTE_ZERO, 0);
		add_byte(BYTE_ONE, eos);
	endtask

	// Start code, header carrying the given type, payload
	task automatic add_unit(input bit four, input logic [KIND_W-1:0] kind,
			input int payload, input bit eos, input bit nonzero_payload);
		logic [7:0] b;
		add_start_code(four, 0);
		for (int i = 0; i <= payload; i++) begin
			if (i == 0)
				b = {3'($urandom), kind};
			else if (nonzero_payload)
				b = 8'($urandom_range(2, 255));
			else
				b = payload_byte();
			add_byte(b, eos && (i == payload));
		end
	endtask

	// One random stream: mostly well-formed units, some noise
	task automatic add_random_stream();
		int units;
		int pic_pct;
		int payload;
		int ending;
		logic [KIND_W-1:0] kind;
		logic [7:0] b;
		if ($urandom_range(0, 9) == 0) begin
			// broken run: zero-heavy noise, maybe ending the stream
			units = $urandom_range(1, 12);
			for (int i = 0; i < units; i++) begin
				case ($urandom_range(0, 3))
					0, 1: b = BYTE_ZERO;
					2: b = BYTE_ONE;
					default: b = 8'($urandom);
				endcase
				add_byte(b, (i == units - 1) && $urandom_range(0, 1));
			end
		end else begin
			for (int i = $urandom_range(0, 2); i > 0; i--)
				add_byte(8'($urandom_range(2, 255)), 0);
			units = $urandom_range(1, 20);
			case ($urandom_range(0, 2))
				0: pic_pct = 0;
				1: pic_pct = 10;
				default: pic_pct = 40;
			endcase
			ending = $urandom_range(0, 3);
			for (int u = 0; u < units; u++) begin
				if ($urandom_range(0, 99) < pic_pct)
					kind = $urandom_range(0, 1) ? KIND_IDR : KIND_NON_IDR;
				else
					kind = 5'($urandom);
				payload = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
					: $urandom_range(0, 8);
				if ($urandom_range(0, 14) == 0)
					add_start_code(1'($urandom_range(0, 1)), 0);  // unit with no header
				else
					add_unit(1'($urandom_range(0, 1)), kind, payload,
						(u == units - 1) && (ending == 0), 0);
			end
			// stream ends with its last unit, on a start code, on trailing zeros, or runs on
			if (ending == 2)
				add_start_code(1'($urandom_range(0, 1)), 1);
			else if (ending == 3) begin
				for (int i = $urandom_range(1, 4); i > 0; i--)
					add_byte(BYTE_ZERO, 0);
				add_byte(8'($urandom), 1);
			end
		end
	endtask

	task automatic add_random_bytes(input int count);
		int target;
		target = bytes_pushed + count;
		while (bytes_pushed < target)
			add_random_stream();
	endtask

	// Sender idles until every byte is in and every report is out
	task automatic wait_quiet();
		while (bytes_taken != bytes_pushed || expected_reports.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_ts_step(input logic [TS_INC_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		ts_step = value;
	endtask

	// Phases
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed opening at the reset increment
		gap_max = 3;
		ready_pattern = 16'($urandom) | 16'h0001;
		add_hex(48'hFF_00_00_00_01_65, 6, 0);            // junk, 4-byte code, IDR
		add_hex(24'h00_00_01, 3, 0);                     // opens a headerless unit
		add_hex(56'h00_00_01_00_00_01_E1, 7, 0);         // header 00 joins next code
		add_hex(72'h00_00_00_00_01_1F_00_00_01, 9, 1);   // end lands on a start code
		add_hex(40'h00_00_01_09_F0, 5, 1);               // unit closed by end
		add_hex(8'h7F, 1, 1);                            // end with no unit open
		wait_quiet();

		// bursty traffic with a full drain half way
		write_ts_step(17'd90000);
		gap_max = 6;
		ready_pattern = 16'($urandom) | 16'h0001;
		add_random_bytes(300);
		wait_quiet();
		ready_pattern = 16'($urandom) | 16'h0001;
		add_random_bytes(250);
		wait_quiet();

		// largest increment, no idling on either side
		write_ts_step(17'h1FFFF);
		gap_max = 0;
		ready_pattern = 16'hFFFF;
		add_random_bytes(200);
		wait_quiet();

		// zero increment, traffic opened by a bare start code
		write_ts_step(17'd0);
		ready_pattern = 16'($urandom) | 16'h0001;
		add_start_code(0, 0);
		gap_max = 4;
		add_random_bytes(150);
		wait_quiet();

		// random increment, sparse ready
		write_ts_step(17'($urandom_range(0, 90000)));
		gap_max = 8;
		ready_pattern = (16'($urandom) & 16'($urandom)) | 16'h0001;
		add_random_bytes(200);
		wait_quiet();

		if (expected_reports.size() != 0)
			log_mismatch($sformatf("%0d unit reports never arrived",
				expected_reports.size()));
		if (mismatch_count == 0)
			$display("annexb_nal_splitter_core: match");
		else
			$display("annexb_nal_splitter_core: mismatch");
		$finish;
	end

endmodule
